@@ rtl/core/bbsr_pkg.sv @@
// Shared types and constants for the bad block spare remapper.
// Holds the command and result structs and their codes. Depends on nothing.
`default_nettype none

package bbsr_pkg;

  localparam int unsigned NUM_BLOCKS_DEF  = 128;
  localparam int unsigned SPARE_COUNT_DEF = 8;

  typedef enum logic [1:0] {
    CMD_MARK  = 2'd0,
    CMD_ALLOC = 2'd1,
    CMD_READ  = 2'd2,
    CMD_NOP   = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    RES_OK        = 2'd0,
    RES_RANGE     = 2'd1,
    RES_EXHAUSTED = 2'd2,
    RES_UNMAPPED  = 2'd3
  } res_status_e;

  typedef enum logic [1:0] {
    BLK_GOOD  = 2'd0,
    BLK_BAD   = 2'd1,
    BLK_SPARE = 2'd2
  } blk_state_e;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] block_addr;
  } cmd_t;

  typedef struct packed {
    logic [6:0] physical_block;
    logic [1:0] status;
    logic       fresh_allocation;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/bbsr_ram.sv @@
// Simple dual-port synchronous RAM with one write and one registered read port.
// Used for the block status and remap tables. Depends on nothing.
`default_nettype none

module bbsr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

@@ rtl/core/bad_block_spare_remapper_top.sv @@
// Top level of the bad block spare remapper: command sequencer around two tables.
// Uses bbsr_pkg for types and codes and bbsr_ram for the status and remap tables.
//
//   channel   signals                 direction  handshake
//   command   start, busy, cmd_i      in         taken when start is high and busy is low
//   result    done_o, result_o        out        one cycle strobe, cannot be held off
//
// For each item the table read is issued at the accepting edge; the read-modify-write
// follows in the execute state, in which busy is high, and its result is registered at
// the end of that state. The registered read port of the tables sets this split.
// After reset a clearing pass over every entry resets both tables; busy is high
// during it. The result is shown for one cycle while the next item may be accepted.
`default_nettype none

module bad_block_spare_remapper_top
  import bbsr_pkg::*;
#(
  parameter int unsigned NUM_BLOCKS  = NUM_BLOCKS_DEF,
  parameter int unsigned SPARE_COUNT = SPARE_COUNT_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    start,
  input  cmd_t    cmd_i,
  output logic    busy,
  output logic    done_o,
  output result_t result_o
);

  localparam int unsigned IDX_W = $clog2(NUM_BLOCKS);
  localparam int unsigned NS_W  = $clog2(NUM_BLOCKS + 1);
  localparam int unsigned MAP_W = IDX_W + 1;
  localparam logic [NS_W-1:0] SPARE_BASE =
      (SPARE_COUNT > NUM_BLOCKS) ? '0 : NS_W'(NUM_BLOCKS - SPARE_COUNT);
  localparam logic [NS_W-1:0]  BLOCK_LIMIT = NS_W'(NUM_BLOCKS);
  localparam logic [IDX_W-1:0] LAST_IDX    = IDX_W'(NUM_BLOCKS - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC
  } state_e;

  state_e            state_q;
  logic [IDX_W-1:0]  clr_q;
  cmd_t              cmd_q;
  logic [NS_W-1:0]   next_spare_q;
  logic              done_q;
  result_t           res_q;
  result_t           res_d;
  logic              spare_take;

  logic [31:0]       in_blk_ext;
  logic [31:0]       ex_blk_ext;
  logic [IDX_W-1:0]  rd_idx;
  logic [IDX_W-1:0]  ex_idx;
  logic              in_range;

  logic [1:0]        status_rd;
  logic [MAP_W-1:0]  map_rd;
  logic              map_valid;
  logic [31:0]       map_ext;
  logic [IDX_W-1:0]  spare_idx;
  logic [31:0]       spare_ext;
  logic              has_spare;

  logic              st_we;
  logic [IDX_W-1:0]  st_waddr;
  logic [1:0]        st_wdata;
  logic              mp_we;
  logic [IDX_W-1:0]  mp_waddr;
  logic [MAP_W-1:0]  mp_wdata;

  assign in_blk_ext = 32'(cmd_i.block_addr);
  assign ex_blk_ext = 32'(cmd_q.block_addr);
  assign rd_idx     = in_blk_ext[IDX_W-1:0];
  assign ex_idx     = ex_blk_ext[IDX_W-1:0];
  assign in_range   = ex_blk_ext < 32'(NUM_BLOCKS);

  assign map_valid  = map_rd[IDX_W];
  assign map_ext    = 32'(map_rd[IDX_W-1:0]);
  assign spare_idx  = next_spare_q[IDX_W-1:0];
  assign spare_ext  = 32'(spare_idx);
  assign has_spare  = next_spare_q < BLOCK_LIMIT;

  bbsr_ram #(
    .WIDTH (2),
    .DEPTH (NUM_BLOCKS)
  ) u_status_ram (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (st_waddr),
    .wdata_i (st_wdata),
    .raddr_i (rd_idx),
    .rdata_o (status_rd)
  );

  bbsr_ram #(
    .WIDTH (MAP_W),
    .DEPTH (NUM_BLOCKS)
  ) u_remap_ram (
    .clk_i   (clk_i),
    .we_i    (mp_we),
    .waddr_i (mp_waddr),
    .wdata_i (mp_wdata),
    .raddr_i (rd_idx),
    .rdata_o (map_rd)
  );

  always_comb begin
    st_we      = 1'b0;
    st_waddr   = ex_idx;
    st_wdata   = BLK_GOOD;
    mp_we      = 1'b0;
    mp_waddr   = ex_idx;
    mp_wdata   = '0;
    res_d      = '0;
    spare_take = 1'b0;
    if (state_q == ST_CLEAR) begin
      st_we    = 1'b1;
      st_waddr = clr_q;
      mp_we    = 1'b1;
      mp_waddr = clr_q;
    end else if (state_q == ST_EXEC) begin
      if (cmd_q.command != CMD_NOP && !in_range) begin
        res_d.status = RES_RANGE;
      end else begin
        unique case (cmd_e'(cmd_q.command))
          CMD_MARK: begin
            st_we                = 1'b1;
            st_wdata             = BLK_BAD;
            res_d.physical_block = cmd_q.block_addr[6:0];
          end
          CMD_ALLOC: begin
            if (map_valid) begin
              res_d.physical_block = map_ext[6:0];
            end else if (has_spare) begin
              st_we                  = 1'b1;
              st_waddr               = spare_idx;
              st_wdata               = BLK_SPARE;
              mp_we                  = 1'b1;
              mp_wdata               = {1'b1, spare_idx};
              spare_take             = 1'b1;
              res_d.physical_block   = spare_ext[6:0];
              res_d.fresh_allocation = 1'b1;
            end else begin
              res_d.status = RES_EXHAUSTED;
            end
          end
          CMD_READ: begin
            if (status_rd == BLK_BAD) begin
              if (map_valid) begin
                res_d.physical_block = map_ext[6:0];
              end else begin
                res_d.status = RES_UNMAPPED;
              end
            end else begin
              res_d.physical_block = cmd_q.block_addr[6:0];
            end
          end
          CMD_NOP: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      cmd_q        <= '0;
      next_spare_q <= SPARE_BASE;
      done_q       <= 1'b0;
      res_q        <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == LAST_IDX) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (start) begin
            cmd_q   <= cmd_i;
            state_q <= ST_EXEC;
          end
        end
        ST_EXEC: begin
          res_q   <= res_d;
          done_q  <= 1'b1;
          state_q <= ST_IDLE;
          if (spare_take) begin
            next_spare_q <= next_spare_q + 1'b1;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign busy     = (state_q != ST_IDLE);
  assign done_o   = done_q;
  assign result_o = res_q;

  a_done_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##2 done_o)
    else $error("result strobe missing two cycles after an accepted item");

  a_done_after_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(state_q == ST_EXEC))
    else $error("result strobe without a preceding execute cycle");

  a_error_zero_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.status != RES_OK) |-> (result_o.physical_block == '0))
    else $error("failed item carries a nonzero block number");

  a_fresh_takes_spare: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && result_o.fresh_allocation) |->
      (result_o.status == RES_OK && next_spare_q == $past(next_spare_q) + 1'b1))
    else $error("fresh allocation without advancing the spare pointer");

  a_spare_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    next_spare_q <= BLOCK_LIMIT)
    else $error("spare pointer ran past the block count");

endmodule

`default_nettype wire

@@ bench/tb.sv @@
`timescale 1ns / 1ps
// Testbench for bad_block_spare_remapper_top: directed and random commands are checked
// against a model of the status table, remap table and spare pointer kept in a class.
// Depends on bbsr_pkg and bad_block_spare_remapper_top.
module tb;
  import bbsr_pkg::*;

  localparam int unsigned NB           = NUM_BLOCKS_DEF;
  localparam int unsigned NSPARE       = SPARE_COUNT_DEF;
  localparam int unsigned IDLE_LIMIT   = 2000;
  localparam int unsigned RANDOM_ITEMS = 1030;

  class remap_tracker;
    blk_state_e  state_of[NB];
    bit          mapped[NB];
    logic [6:0]  spare_of[NB];
    int unsigned next_spare;
    result_t     pending_results[$];
    int unsigned fails;

    function new();
      foreach (state_of[i]) begin
        state_of[i] = BLK_GOOD;
        mapped[i]   = 1'b0;
        spare_of[i] = '0;
      end
      next_spare = (NSPARE > NB) ? 0 : NB - NSPARE;
      fails      = 0;
    endfunction

    function void take_command(cmd_t c);
      result_t     r;
      int unsigned b;
      r = '0;
      b = 32'(c.block_addr);
      if (c.command != CMD_NOP) begin
        if (b >= NB) begin
          r.status = RES_RANGE;
        end else begin
          case (c.command)
            CMD_MARK: begin
              state_of[b]      = BLK_BAD;
              r.physical_block = c.block_addr[6:0];
            end
            CMD_ALLOC: begin
              if (mapped[b]) begin
                r.physical_block = spare_of[b];
              end else if (next_spare < NB) begin
                state_of[next_spare] = BLK_SPARE;
                spare_of[b]          = next_spare[6:0];
                mapped[b]            = 1'b1;
                r.physical_block     = next_spare[6:0];
                r.fresh_allocation   = 1'b1;
                next_spare           = next_spare + 1;
              end else begin
                r.status = RES_EXHAUSTED;
              end
            end
            default: begin
              if (state_of[b] != BLK_BAD) begin
                r.physical_block = c.block_addr[6:0];
              end else if (mapped[b]) begin
                r.physical_block = spare_of[b];
              end else begin
                r.status = RES_UNMAPPED;
              end
            end
          endcase
        end
      end
      pending_results.push_back(r);
    endfunction

    function void match_result(result_t got);
      result_t want;
      if (pending_results.size() == 0) begin
        $error("result %h arrived with no command waiting", got);
        fails++;
      end else begin
        want = pending_results.pop_front();
        if (got.physical_block !== want.physical_block) begin
          $error("physical_block: expected %0d, actual %0d", want.physical_block,
                 got.physical_block);
          fails++;
        end
        if (got.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got.status);
          fails++;
        end
        if (got.fresh_allocation !== want.fresh_allocation) begin
          $error("fresh_allocation: expected %0d, actual %0d", want.fresh_allocation,
                 got.fresh_allocation);
          fails++;
        end
      end
    endfunction
  endclass

  logic    clk_i  = 1'b0;
  logic    rst_ni = 1'b0;
  logic    start  = 1'b0;
  cmd_t    cmd_i  = '0;
  logic    busy;
  logic    done_o;
  result_t result_o;

  remap_tracker tracker = new();
  int unsigned  idle_cycles = 0;

  bad_block_spare_remapper_top dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .cmd_i    (cmd_i),
    .busy     (busy),
    .done_o   (done_o),
    .result_o (result_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && busy === 1'b0) begin
        tracker.take_command(cmd_i);
      end
      if (done_o !== 1'b0) begin
        tracker.match_result(result_o);
      end
      if ((start && busy === 1'b0) || done_o !== 1'b0) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  function automatic cmd_t make_cmd(cmd_e op, int unsigned blk);
    cmd_t c;
    c.command    = op;
    c.block_addr = blk[7:0];
    return c;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 85) return $urandom_range(1, 3);
    if (p < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic send_command(cmd_t c, int unsigned gap);
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    cmd_i <= c;
    do @(posedge clk_i); while (busy !== 1'b0);
  endtask

  initial begin
    cmd_t        plan[$];
    cmd_t        c;
    int unsigned pick;
    bit          burst;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    plan.push_back(make_cmd(CMD_READ, 5));
    plan.push_back(make_cmd(CMD_MARK, 0));
    plan.push_back(make_cmd(CMD_READ, 0));
    plan.push_back(make_cmd(CMD_ALLOC, 0));
    plan.push_back(make_cmd(CMD_READ, 0));
    plan.push_back(make_cmd(CMD_ALLOC, 0));
    plan.push_back(make_cmd(CMD_ALLOC, NB - 1));
    plan.push_back(make_cmd(CMD_READ, NB - 1));
    plan.push_back(make_cmd(CMD_MARK, NB - 1));
    plan.push_back(make_cmd(CMD_READ, NB - 1));
    plan.push_back(make_cmd(CMD_ALLOC, NB - NSPARE));
    plan.push_back(make_cmd(CMD_READ, NB - NSPARE));
    plan.push_back(make_cmd(CMD_MARK, NB - NSPARE + 1));
    plan.push_back(make_cmd(CMD_READ, NB - NSPARE + 1));
    plan.push_back(make_cmd(CMD_MARK, NB));
    plan.push_back(make_cmd(CMD_ALLOC, 200));
    plan.push_back(make_cmd(CMD_READ, 255));
    plan.push_back(make_cmd(CMD_NOP, 255));
    plan.push_back(make_cmd(CMD_NOP, 0));
    for (int unsigned b = 3; b < 3 + NSPARE; b++) begin
      plan.push_back(make_cmd(CMD_ALLOC, b));
    end
    plan.push_back(make_cmd(CMD_READ, 3));

    foreach (plan[i]) begin
      send_command(plan[i], pick_gap());
    end

    burst = 1'b0;
    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n % 64 == 0) begin
        burst = ($urandom_range(0, 3) == 0);
      end
      pick = $urandom_range(0, 99);
      if (pick < 30) begin
        c.command = CMD_MARK;
      end else if (pick < 75) begin
        c.command = CMD_READ;
      end else if (pick < 87) begin
        c.command = CMD_ALLOC;
      end else begin
        c.command = CMD_NOP;
      end
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        c.block_addr = 8'($urandom_range(NB, 255));
      end else if (pick < 40) begin
        c.block_addr = 8'($urandom_range(0, 15));
      end else if (pick < 55) begin
        c.block_addr = 8'($urandom_range(NB - NSPARE, NB - 1));
      end else begin
        c.block_addr = 8'($urandom_range(0, NB - 1));
      end
      send_command(c, burst ? 0 : pick_gap());
    end

    start <= 1'b0;
    @(posedge clk_i);
    while (tracker.pending_results.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (tracker.fails == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
